[hdl/linear_probe_hash_insert_assert.svh]
// assertion macros for the hash table block
`ifndef LINEAR_PROBE_HASH_INSERT_ASSERT_SVH
`define LINEAR_PROBE_HASH_INSERT_ASSERT_SVH

// same-cycle implication
`define LPH_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define LPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[hdl/lph_pkg.sv]
`default_nettype none
package lph_pkg;
	localparam int IDX_W = 4;
	localparam int TABLE_SIZE = 2 ** IDX_W;
	localparam int KEY_W = 31;
	localparam int VAL_W = 32;
	localparam int SLOT_W = 4;
	localparam int ACT_W = 2;
	localparam int KIND_W = 2;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_READ = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

	localparam logic [KIND_W-1:0] RES_INSERTED = 2'd0;
	localparam logic [KIND_W-1:0] RES_FULL = 2'd1;
	localparam logic [KIND_W-1:0] RES_SLOT = 2'd2;
	localparam logic [KIND_W-1:0] RES_CLEARED = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_READ,
		ST_RDOUT,
		ST_CLEAR
	} lph_state_t;

	typedef struct packed {
		logic load;
		logic advance;
		logic ins_write;
		logic emit_ins;
		logic emit_drop;
		logic clear_all;
		logic rd_issue;
		logic emit_read;
	} lph_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic last_probe;
	} lph_status_t;
endpackage
`default_nettype wire

[hdl/lph_ctrl.sv]
`default_nettype none
module lph_ctrl
	import lph_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [ACT_W-1:0]  action,
	input  wire lph_status_t       status,
	output lph_cmd_t               cmd,
	output logic                   busy
);
	lph_state_t state_q;
	lph_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (action)
						ACT_INSERT: state_d = ST_PROBE;
						ACT_CLEAR:  state_d = ST_CLEAR;
						ACT_READ:   state_d = ST_READ;
						default:    state_d = ST_READ;
					endcase
				end
			end
			ST_PROBE: begin
				if (status.slot_free || status.last_probe) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ:  state_d = ST_RDOUT;
			ST_RDOUT: state_d = ST_IDLE;
			ST_CLEAR: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load = start;
			ST_PROBE: begin
				priority if (status.slot_free) begin
					cmd.ins_write = 1'b1;
					cmd.emit_ins = 1'b1;
				end else if (status.last_probe) begin
					cmd.emit_drop = 1'b1;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			ST_READ:  cmd.rd_issue = 1'b1;
			ST_RDOUT: cmd.emit_read = 1'b1;
			ST_CLEAR: cmd.clear_all = 1'b1;
			default:  cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
endmodule
`default_nettype wire

[hdl/lph_datapath.sv]
`default_nettype none
module lph_datapath
	import lph_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire lph_cmd_t                 cmd,
	input  wire logic [KEY_W-1:0]         item_key,
	input  wire logic signed [VAL_W-1:0]  item_value,
	input  wire logic [SLOT_W-1:0]        read_slot,
	output lph_status_t                   status,
	output logic                          done,
	output logic [KIND_W-1:0]             result_kind,
	output logic [SLOT_W-1:0]             slot_index,
	output logic                          slot_occupied,
	output logic [KEY_W-1:0]              slot_key,
	output logic signed [VAL_W-1:0]       slot_value
);
	logic [TABLE_SIZE-1:0]     valid_q;
	logic [KEY_W-1:0]          mem_key [TABLE_SIZE];
	logic signed [VAL_W-1:0]   mem_val [TABLE_SIZE];

	logic [KEY_W-1:0]          key_q;
	logic signed [VAL_W-1:0]   value_q;
	logic [SLOT_W-1:0]         rslot_q;
	logic [IDX_W-1:0]          pos_q;
	logic [IDX_W-1:0]          cnt_q;

	logic [KEY_W-1:0]          rd_key_q;
	logic signed [VAL_W-1:0]   rd_val_q;
	logic                      rd_occ_q;

	logic                      done_q;
	logic [KIND_W-1:0]         kind_q;
	logic [SLOT_W-1:0]         idx_q;
	logic                      occ_q;
	logic [KEY_W-1:0]          okey_q;
	logic signed [VAL_W-1:0]   oval_q;

	logic [IDX_W+SLOT_W-1:0]   rd_wide;
	logic [IDX_W-1:0]          rd_addr;
	logic                      rd_in_range;
	logic [IDX_W+SLOT_W-1:0]   pos_wide;
	logic [SLOT_W-1:0]         pos_slot;

	assign rd_wide = {{IDX_W{1'b0}}, rslot_q};
	assign rd_addr = rd_wide[IDX_W-1:0];
	assign rd_in_range = (rd_wide < (IDX_W + SLOT_W)'(TABLE_SIZE));
	assign pos_wide = {{SLOT_W{1'b0}}, pos_q};
	assign pos_slot = pos_wide[SLOT_W-1:0];

	assign status.slot_free = ~valid_q[pos_q];
	assign status.last_probe = (cnt_q == IDX_W'(TABLE_SIZE - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear_all) begin
			valid_q <= '0;
		end else if (cmd.ins_write) begin
			valid_q[pos_q] <= 1'b1;
		end
	end

	// item capture and probe walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= item_key;
			value_q <= item_value;
			rslot_q <= read_slot;
			pos_q <= item_key[IDX_W-1:0];
			cnt_q <= '0;
		end else if (cmd.advance) begin
			pos_q <= pos_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			mem_key[pos_q] <= key_q;
			mem_val[pos_q] <= value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rd_key_q <= mem_key[rd_addr];
			rd_val_q <= mem_val[rd_addr];
			rd_occ_q <= rd_in_range & valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_ins | cmd.emit_drop | cmd.clear_all | cmd.emit_read;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ins) begin
			kind_q <= RES_INSERTED;
			idx_q <= pos_slot;
			occ_q <= 1'b1;
			okey_q <= key_q;
			oval_q <= value_q;
		end else if (cmd.emit_drop) begin
			kind_q <= RES_FULL;
			idx_q <= '0;
			occ_q <= 1'b0;
			okey_q <= '0;
			oval_q <= '0;
		end else if (cmd.clear_all) begin
			kind_q <= RES_CLEARED;
			idx_q <= '0;
			occ_q <= 1'b0;
			okey_q <= '0;
			oval_q <= '0;
		end else if (cmd.emit_read) begin
			kind_q <= RES_SLOT;
			idx_q <= rslot_q;
			occ_q <= rd_occ_q;
			okey_q <= rd_occ_q ? rd_key_q : '0;
			oval_q <= rd_occ_q ? rd_val_q : '0;
		end
	end

	assign done = done_q;
	assign result_kind = kind_q;
	assign slot_index = idx_q;
	assign slot_occupied = occ_q;
	assign slot_key = okey_q;
	assign slot_value = oval_q;
endmodule
`default_nettype wire

[hdl/linear_probe_hash_insert.sv]
// channel   direction  handshake                  payload
// command   in         start, taken when !busy    action, item_key, item_value, read_slot
// result    out        done, one-cycle strobe     result_kind, slot_index, slot_occupied,
//                                                 slot_key, slot_value
//
// insert: busy while probing, k = slots probed (1 to 16), one probe per cycle
//   against the valid flops; result strobes in the same cycle that busy drops
// read: busy through ST_READ (registered key/value memory read), then ST_RDOUT (result)
// clear: busy only in ST_CLEAR; all valid bits drop together, no sweep
// reset clears the valid bits at once; the next item may start while done shows
// no backpressure: the receiver cannot hold off done, so the result side never stalls
`default_nettype none
module linear_probe_hash_insert
	import lph_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [ACT_W-1:0]         action,
	input  wire logic [KEY_W-1:0]         item_key,
	input  wire logic signed [VAL_W-1:0]  item_value,
	input  wire logic [SLOT_W-1:0]        read_slot,
	output logic                          done,
	output logic [KIND_W-1:0]             result_kind,
	output logic [SLOT_W-1:0]             slot_index,
	output logic                          slot_occupied,
	output logic [KEY_W-1:0]              slot_key,
	output logic signed [VAL_W-1:0]       slot_value
);
	lph_cmd_t    cmd;
	lph_status_t status;

	lph_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	lph_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.item_key      (item_key),
		.item_value    (item_value),
		.read_slot     (read_slot),
		.status        (status),
		.done          (done),
		.result_kind   (result_kind),
		.slot_index    (slot_index),
		.slot_occupied (slot_occupied),
		.slot_key      (slot_key),
		.slot_value    (slot_value)
	);
endmodule
`default_nettype wire

[hdl/lph_checker.sv]
`default_nettype none
`include "linear_probe_hash_insert_assert.svh"
module lph_checker
	import lph_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     start,
	input wire logic                     busy,
	input wire logic [ACT_W-1:0]         action,
	input wire logic [KEY_W-1:0]         item_key,
	input wire logic signed [VAL_W-1:0]  item_value,
	input wire logic [SLOT_W-1:0]        read_slot,
	input wire logic                     done,
	input wire logic [KIND_W-1:0]        result_kind,
	input wire logic [SLOT_W-1:0]        slot_index,
	input wire logic                     slot_occupied,
	input wire logic [KEY_W-1:0]         slot_key,
	input wire logic signed [VAL_W-1:0]  slot_value
);
	logic no_payload;
	logic accepted;
	logic zero_kind;
	logic ins_done;

	assign no_payload = (slot_index == '0) && !slot_occupied && (slot_key == '0)
		&& (slot_value == '0);
	assign accepted = start && !busy;
	assign zero_kind = done && (result_kind == RES_FULL || result_kind == RES_CLEARED);
	assign ins_done = done && (result_kind == RES_INSERTED);

	`LPH_ASSERT_NEXT(a_accept_busy, clk, arst_n, accepted, busy, "accepted item not busy")
	`LPH_ASSERT(a_done_after_busy, clk, arst_n, done, $past(busy), "result without work")
	`LPH_ASSERT(a_busy_end_done, clk, arst_n, $fell(busy), done, "item ended without result")
	`LPH_ASSERT(a_zero_payload, clk, arst_n, zero_kind, no_payload, "payload not zero")
	`LPH_ASSERT(a_insert_occ, clk, arst_n, ins_done, slot_occupied, "insert not occupied")
endmodule

bind linear_probe_hash_insert lph_checker u_lph_checker (.*);
`default_nettype wire

[tb/lph_table_checker.sv]
`default_nettype none
module lph_table_checker
	import lph_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic                     busy,
	input  wire logic [ACT_W-1:0]         action,
	input  wire logic [KEY_W-1:0]         item_key,
	input  wire logic signed [VAL_W-1:0]  item_value,
	input  wire logic [SLOT_W-1:0]        read_slot,
	input  wire logic                     done,
	input  wire logic [KIND_W-1:0]        result_kind,
	input  wire logic [SLOT_W-1:0]        slot_index,
	input  wire logic                     slot_occupied,
	input  wire logic [KEY_W-1:0]         slot_key,
	input  wire logic signed [VAL_W-1:0]  slot_value,
	output int                            fail_count,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] index;
		logic              occupied;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} slot_report_t;

	logic             table_valid [TABLE_SIZE];
	logic [KEY_W-1:0] table_key   [TABLE_SIZE];
	logic [VAL_W-1:0] table_value [TABLE_SIZE];
	slot_report_t     expected_reports [$];

	function automatic slot_report_t apply_table_op(input logic [ACT_W-1:0] act,
			input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val,
			input logic [SLOT_W-1:0] slot);
		slot_report_t rep;
		int unsigned pos;
		int n;
		logic placed;
		rep = '0;
		if (act == ACT_INSERT) begin
			rep.kind = RES_FULL;
			pos = key % TABLE_SIZE;
			n = 0;
			placed = 1'b0;
			while (n < TABLE_SIZE && !placed) begin
				if (!table_valid[pos]) begin
					table_valid[pos] = 1'b1;
					table_key[pos] = key;
					table_value[pos] = val;
					rep.kind = RES_INSERTED;
					rep.index = SLOT_W'(pos);
					rep.occupied = 1'b1;
					rep.key = key;
					rep.value = val;
					placed = 1'b1;
				end
				pos = (pos + 1) % TABLE_SIZE;
				n++;
			end
		end else if (act == ACT_CLEAR) begin
			for (int i = 0; i < TABLE_SIZE; i++)
				table_valid[i] = 1'b0;
			rep.kind = RES_CLEARED;
		end else begin
			// read, the spare action code included
			rep.kind = RES_SLOT;
			rep.index = slot;
			if (int'(slot) < TABLE_SIZE && table_valid[slot]) begin
				rep.occupied = 1'b1;
				rep.key = table_key[slot];
				rep.value = table_value[slot];
			end
		end
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin : result_check
		slot_report_t exp_rep;
		int bad;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++) begin
				table_valid[i] = 1'b0;
				table_key[i] = '0;
				table_value[i] = '0;
			end
			expected_reports.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;
			if (done) begin
				if (expected_reports.size() == 0) begin
					$error("result with no item pending: kind %0d slot %0d",
						result_kind, slot_index);
					bad++;
				end else begin
					exp_rep = expected_reports.pop_front();
					if (result_kind !== exp_rep.kind) begin
						$error("result_kind expected %0d got %0d", exp_rep.kind, result_kind);
						bad++;
					end
					if (slot_index !== exp_rep.index) begin
						$error("slot_index expected %0d got %0d", exp_rep.index, slot_index);
						bad++;
					end
					if (slot_occupied !== exp_rep.occupied) begin
						$error("slot_occupied expected %0b got %0b",
							exp_rep.occupied, slot_occupied);
						bad++;
					end
					if (slot_key !== exp_rep.key) begin
						$error("slot_key expected %0h got %0h", exp_rep.key, slot_key);
						bad++;
					end
					if (slot_value !== exp_rep.value) begin
						$error("slot_value expected %0h got %0h", exp_rep.value, slot_value);
						bad++;
					end
				end
			end
			if (start && !busy)
				expected_reports.push_back(apply_table_op(action, item_key, item_value,
					read_slot));
			fail_count <= fail_count + bad;
			outstanding <= expected_reports.size();
		end
	end
endmodule
`default_nettype wire

[tb/linear_probe_hash_insert_tb.sv]
`default_nettype none
module linear_probe_hash_insert_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lph_pkg::*;

	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 1450;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [ACT_W-1:0]        action;
	logic [KEY_W-1:0]        item_key;
	logic signed [VAL_W-1:0] item_value;
	logic [SLOT_W-1:0]       read_slot;
	logic                    done;
	logic [KIND_W-1:0]       result_kind;
	logic [SLOT_W-1:0]       slot_index;
	logic                    slot_occupied;
	logic [KEY_W-1:0]        slot_key;
	logic signed [VAL_W-1:0] slot_value;

	int mismatches;
	int reports_due;
	int idle_pct;
	int items_sent;
	int quiet_cycles = 0;

	linear_probe_hash_insert u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.item_key      (item_key),
		.item_value    (item_value),
		.read_slot     (read_slot),
		.done          (done),
		.result_kind   (result_kind),
		.slot_index    (slot_index),
		.slot_occupied (slot_occupied),
		.slot_key      (slot_key),
		.slot_value    (slot_value)
	);

	lph_table_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.item_key      (item_key),
		.item_value    (item_value),
		.read_slot     (read_slot),
		.done          (done),
		.result_kind   (result_kind),
		.slot_index    (slot_index),
		.slot_occupied (slot_occupied),
		.slot_key      (slot_key),
		.slot_value    (slot_value),
		.fail_count    (mismatches),
		.outstanding   (reports_due)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("linear_probe_hash_insert: mismatch");
				$finish;
			end
		end
	end

	task automatic issue_item(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] val, input logic [SLOT_W-1:0] slot);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		action <= act;
		item_key <= key;
		item_value <= val;
		read_slot <= slot;
		do @(posedge clk); while (busy);
		@(negedge clk);
		items_sent++;
	endtask

	function automatic logic [KEY_W-1:0] pick_key(input logic [KEY_W-1:0] prev);
		case ($urandom_range(0, 5))
			0: return prev;
			// hashes bunched around the wrap point
			1, 2: return (KEY_W'($urandom) & ~KEY_W'(TABLE_SIZE - 1))
				| KEY_W'(($urandom_range(0, 3) + TABLE_SIZE - 2) % TABLE_SIZE);
			3: return $urandom_range(0, 1) ? '0 : '1;
			default: return KEY_W'($urandom);
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return {1'b1, {(VAL_W-1){1'b0}}};
			1: return {1'b0, {(VAL_W-1){1'b1}}};
			2: return '1;
			3: return '0;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] last_key;
		logic [ACT_W-1:0] rd_act;
		int ins_pct;
		int roll;
		int rand_base;
		start = 1'b0;
		action = ACT_INSERT;
		item_key = '0;
		item_value = '0;
		read_slot = '0;
		arst_n = 1'b0;
		idle_pct = 25;
		items_sent = 0;
		last_key = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty reads, the spare code, collisions, wrap, duplicate key, full table, clear
		issue_item(ACT_READ, '0, '0, 4'd0);
		issue_item(ACT_READ, '1, '1, 4'd15);
		issue_item(ACT_SPARE, '0, '0, 4'd7);
		issue_item(ACT_INSERT, '0, 32'h7FFF_FFFF, '0);
		issue_item(ACT_INSERT, 31'd16, 32'h8000_0000, '1);
		issue_item(ACT_INSERT, '1, '1, '0);
		issue_item(ACT_INSERT, 31'd31, 32'd1, '0);
		issue_item(ACT_INSERT, '0, 32'd5, '0);
		issue_item(ACT_READ, '0, '0, 4'd0);
		issue_item(ACT_READ, '0, '0, 4'd1);
		issue_item(ACT_READ, '0, '0, 4'd15);
		issue_item(ACT_SPARE, '0, '0, 4'd2);
		for (int i = 0; i < 11; i++)
			issue_item(ACT_INSERT, KEY_W'(15 + TABLE_SIZE * i), VAL_W'($urandom), '0);
		issue_item(ACT_INSERT, 31'd9, '1, '0);
		issue_item(ACT_CLEAR, '0, '0, '0);
		issue_item(ACT_READ, '0, '0, 4'd15);

		rand_base = items_sent;
		while (items_sent - rand_base < RANDOM_ITEMS) begin
			if (items_sent - rand_base < RANDOM_ITEMS / 3)
				idle_pct = 25;
			else if (items_sent - rand_base < 2 * RANDOM_ITEMS / 3)
				idle_pct = 64;
			else
				idle_pct = 0;
			case ($urandom_range(0, 2))
				0: ins_pct = 30;
				1: ins_pct = 60;
				default: ins_pct = 95;
			endcase
			if ($urandom_range(0, 2) == 0)
				issue_item(ACT_CLEAR, KEY_W'($urandom), VAL_W'($urandom), SLOT_W'($urandom));
			repeat ($urandom_range(4, 40)) begin
				roll = $urandom_range(0, 99);
				if (roll < ins_pct) begin
					k = pick_key(last_key);
					last_key = k;
					issue_item(ACT_INSERT, k, pick_value(), SLOT_W'($urandom));
				end else if (roll < 97) begin
					rd_act = ($urandom_range(0, 7) == 0) ? ACT_SPARE : ACT_READ;
					issue_item(rd_act, KEY_W'($urandom), VAL_W'($urandom), SLOT_W'($urandom));
				end else begin
					issue_item(ACT_CLEAR, KEY_W'($urandom), VAL_W'($urandom), SLOT_W'($urandom));
				end
			end
		end
		start <= 1'b0;

		wait (reports_due == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("linear_probe_hash_insert: match");
		else
			$display("linear_probe_hash_insert: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
+incdir+hdl
hdl/lph_pkg.sv
hdl/lph_ctrl.sv
hdl/lph_datapath.sv
hdl/linear_probe_hash_insert.sv
hdl/lph_checker.sv
tb/lph_table_checker.sv
tb/linear_probe_hash_insert_tb.sv
